[hdl/sorted_edge_pwm_scheduler_core_assert.svh]
// ----------------------------------------------------------------------------
// sorted edge pwm scheduler assertion macros
// clocked property checks shared by the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_EDGE_PWM_SCHEDULER_CORE_ASSERT_SVH
`define SORTED_EDGE_PWM_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SEPWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sepwm check failed");

// next-cycle implication, checked outside reset
`define SEPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sepwm check failed");

`endif

[hdl/sepwm_pkg.sv]
// ----------------------------------------------------------------------------
// sepwm_pkg
// item codes and field widths of the sorted edge pwm scheduler
// ----------------------------------------------------------------------------
package sepwm_pkg;

  // item kinds carried on the slave tuser
  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_COMMIT  = 2'd1,
    MODE_COMPARE = 2'd2
  } mode_e;

  localparam int MODE_W   = 2;
  localparam int CHAN_W   = 3;
  localparam int OFF_W    = 7;
  localparam int MASK_W   = 8;
  localparam int IVL_W    = 7;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

endpackage

[hdl/sorted_edge_pwm_scheduler_core.sv]
// ----------------------------------------------------------------------------
// sorted_edge_pwm_scheduler_core
// multi-channel led pwm with double-buffered, sorted off-time tables
// ----------------------------------------------------------------------------
// Items enter on the slave stream with the item kind on tuser: a write stores
// one channel's off-time (clamped to PWM_PERIOD, which means dark) in the back
// bank, a commit stably bubble-sorts the back bank's channel order and asks
// for a bank swap, and a compare event steps the pwm cycle and gives one
// result (led mask and ticks to the next edge) on the master stream. All
// other kinds give no result. The block takes one item at a time: a compare
// event reads the previous and current positions' orders and off-times
// before it forms its result (the cycle-end step forms it at once), and a
// commit's sort is paced by the single compare unit and the one read port
// of the order and off-time memories that it walks. A result waits in the
// output register and a compare event stalls only when that register is
// still full. After reset every off-time reads as dark and every order as
// identity; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_edge_pwm_scheduler_core #(
  parameter int CHANNELS   = 8,
  parameter int PWM_PERIOD = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: channel [2:0], off_time [9:3], zero fill above
  input  logic [sepwm_pkg::S_DATA_W-1:0] s_axis_tdata,
  // tuser: mode [1:0]
  input  logic [sepwm_pkg::MODE_W-1:0]   s_axis_tuser,
  // master stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: led_mask [7:0], next_interval [14:8], zero fill above
  output logic [sepwm_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import sepwm_pkg::*;

  // widths derived from the channel count and the period
  localparam int IW        = $clog2(CHANNELS);        // position / channel index
  localparam int AW        = IW + 1;                  // bank plus position
  localparam int MEM_DEPTH = 2 ** AW;
  localparam int OW        = $clog2(PWM_PERIOD + 1);  // stored off-time
  localparam int SW        = $clog2(CHANNELS + 2);    // step within a pwm cycle

  // sequencer codes
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_S_ORD0  = 4'd1;  // sort: fetch order of position 0
  localparam logic [3:0] ST_S_OFF0  = 4'd2;  // sort: fetch its off-time
  localparam logic [3:0] ST_S_CARRY = 4'd3;  // sort: latch carried element
  localparam logic [3:0] ST_S_ORDN  = 4'd4;  // sort: next element's order in
  localparam logic [3:0] ST_S_CMP   = 4'd5;  // sort: compare and swap
  localparam logic [3:0] ST_S_DEP   = 4'd6;  // sort: drop carried element
  localparam logic [3:0] ST_C_ORDA  = 4'd7;  // step: fetch previous order
  localparam logic [3:0] ST_C_OFFA  = 4'd8;  // step: fetch its off-time
  localparam logic [3:0] ST_C_OFFB  = 4'd9;  // step: fetch current off-time
  localparam logic [3:0] ST_C_RES   = 4'd10; // step: form result

  // input fields
  logic [CHAN_W-1:0] s_channel;
  logic [OFF_W-1:0]  s_off_time;
  logic              s_fire;
  assign s_channel  = s_axis_tdata[CHAN_W-1:0];
  assign s_off_time = s_axis_tdata[CHAN_W+OFF_W-1:CHAN_W];
  assign s_fire     = s_axis_tvalid && s_axis_tready;

  // control state
  logic [3:0]    state_q, state_d;
  logic [SW-1:0] step_q, step_d;
  logic          front_q, front_d;
  logic          swap_q, swap_d;
  logic          bank_q, bank_d;
  logic [MASK_W-1:0] lit_q, lit_d;
  logic          m_valid_q, m_valid_d;

  // sorter registers
  logic [IW-1:0] pass_q, pass_d;
  logic [IW-1:0] k_q, k_d;
  logic          moved_q, moved_d;
  logic [IW-1:0] carry_ord_q, carry_ord_d;
  logic [OW-1:0] carry_off_q, carry_off_d;
  logic [IW-1:0] new_ord_q, new_ord_d;

  // step registers
  logic [IW-1:0] prev_ord_q, prev_ord_d;
  logic [OW-1:0] prev_off_q, prev_off_d;
  logic [IW-1:0] cur_ord_q, cur_ord_d;

  // result payload
  logic [MASK_W-1:0] m_mask_q, m_mask_d;
  logic [IVL_W-1:0]  m_ivl_q, m_ivl_d;

  // memories: order and off-time, one read and one write port each
  logic [IW-1:0]        ord_mem [MEM_DEPTH];
  logic [OW-1:0]        off_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] ord_vld_q, off_vld_q;
  logic [AW-1:0]        ord_ra, off_ra, ord_wa, off_wa;
  logic                 ord_we, off_we;
  logic [IW-1:0]        ord_wd, ord_rd_q;
  logic [OW-1:0]        off_wd, off_rd_q;

  // shared compare/subtract datapath
  logic [IW-1:0] kp1, kp2;
  logic [IW-1:0] pos_a, pos_b;
  logic [OW-1:0] ivl;
  logic [OW-1:0] clamped_off;
  logic          more_swap;

  assign kp1 = k_q + IW'(1);
  assign kp2 = kp1 + IW'(1);

  // positions used by the current step, held in range at the cycle edges
  assign pos_a = (step_q == '0) ? '0 : IW'(step_q - SW'(1));
  assign pos_b = (step_q >= SW'(CHANNELS)) ? IW'(CHANNELS - 1) : IW'(step_q);

  assign clamped_off = ({2'b00, s_off_time} > (OFF_W+2)'(PWM_PERIOD)) ?
                       OW'(PWM_PERIOD) : OW'(s_off_time);

  // stable order: swap only when strictly greater
  assign more_swap = carry_off_q > off_rd_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    front_d     = front_q;
    swap_d      = swap_q;
    bank_d      = bank_q;
    lit_d       = lit_q;
    m_valid_d   = m_valid_q;
    pass_d      = pass_q;
    k_d         = k_q;
    moved_d     = moved_q;
    carry_ord_d = carry_ord_q;
    carry_off_d = carry_off_q;
    new_ord_d   = new_ord_q;
    prev_ord_d  = prev_ord_q;
    prev_off_d  = prev_off_q;
    cur_ord_d   = cur_ord_q;
    m_mask_d    = m_mask_q;
    m_ivl_d     = m_ivl_q;
    ord_ra      = {bank_q, k_q};
    off_ra      = {bank_q, cur_ord_q};
    ord_we      = 1'b0;
    ord_wa      = {bank_q, k_q};
    ord_wd      = new_ord_q;
    off_we      = 1'b0;
    off_wa      = {~front_q, IW'(s_channel)};
    off_wd      = clamped_off;
    ivl         = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (mode_e'(s_axis_tuser))
            MODE_WRITE: begin
              // channels beyond the table are dropped
              off_we = (32'(s_channel) < CHANNELS);
            end
            MODE_COMMIT: begin
              bank_d  = ~front_q;
              swap_d  = 1'b1;
              pass_d  = IW'(CHANNELS - 1);
              k_d     = '0;
              moved_d = 1'b0;
              state_d = ST_S_ORD0;
            end
            MODE_COMPARE: begin
              if (step_q == SW'(CHANNELS + 1)) begin
                state_d = ST_C_RES;
              end else begin
                // banks flip only at the start of a pwm cycle
                if (step_q == '0 && swap_q) begin
                  front_d = ~front_q;
                  swap_d  = 1'b0;
                  bank_d  = ~front_q;
                end else begin
                  bank_d  = front_q;
                end
                state_d = ST_C_ORDA;
              end
            end
            default: begin
              // unused kind, no result
            end
          endcase
        end
      end

      ST_S_ORD0: begin
        ord_ra  = {bank_q, IW'(0)};
        state_d = ST_S_OFF0;
      end

      ST_S_OFF0: begin
        carry_ord_d = ord_rd_q;
        off_ra      = {bank_q, ord_rd_q};
        ord_ra      = {bank_q, kp1};
        state_d     = ST_S_CARRY;
      end

      ST_S_CARRY: begin
        carry_off_d = off_rd_q;
        new_ord_d   = ord_rd_q;
        off_ra      = {bank_q, ord_rd_q};
        state_d     = ST_S_CMP;
      end

      ST_S_ORDN: begin
        new_ord_d = ord_rd_q;
        off_ra    = {bank_q, ord_rd_q};
        state_d   = ST_S_CMP;
      end

      ST_S_CMP: begin
        if (more_swap) begin
          // smaller element settles at k, larger one carries on
          ord_we  = 1'b1;
          ord_wa  = {bank_q, k_q};
          ord_wd  = new_ord_q;
          moved_d = 1'b1;
        end else begin
          // carried element settles at k, the next one carries on
          ord_we      = 1'b1;
          ord_wa      = {bank_q, k_q};
          ord_wd      = carry_ord_q;
          carry_ord_d = new_ord_q;
          carry_off_d = off_rd_q;
        end
        if (kp1 == pass_q) begin
          state_d = ST_S_DEP;
        end else begin
          ord_ra  = {bank_q, kp2};
          k_d     = kp1;
          state_d = ST_S_ORDN;
        end
      end

      ST_S_DEP: begin
        ord_we = 1'b1;
        ord_wa = {bank_q, pass_q};
        ord_wd = carry_ord_q;
        // a pass without a swap ends the sort early
        if (!moved_q || pass_q == IW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          pass_d  = pass_q - IW'(1);
          k_d     = '0;
          moved_d = 1'b0;
          state_d = ST_S_ORD0;
        end
      end

      ST_C_ORDA: begin
        ord_ra  = {bank_q, pos_a};
        state_d = ST_C_OFFA;
      end

      ST_C_OFFA: begin
        prev_ord_d = ord_rd_q;
        off_ra     = {bank_q, ord_rd_q};
        ord_ra     = {bank_q, pos_b};
        state_d    = ST_C_OFFB;
      end

      ST_C_OFFB: begin
        prev_off_d = off_rd_q;
        cur_ord_d  = ord_rd_q;
        off_ra     = {bank_q, ord_rd_q};
        state_d    = ST_C_RES;
      end

      ST_C_RES: begin
        // off_ra keeps the current channel, so off_rd_q holds while stalled
        if (!m_valid_q || m_axis_tready) begin
          if (step_q == SW'(CHANNELS + 1)) begin
            lit_d  = '0;
            ivl    = '0;
            step_d = '0;
          end else if (step_q == '0) begin
            ivl    = off_rd_q;
            step_d = SW'(1);
          end else begin
            if (prev_off_q != OW'(PWM_PERIOD) && 32'(prev_ord_q) < MASK_W) begin
              lit_d[3'(prev_ord_q)] = 1'b1;
            end
            if (step_q == SW'(CHANNELS)) begin
              ivl = OW'(PWM_PERIOD) - prev_off_q;
            end else begin
              // unsorted front bank: negative gap saturates
              ivl = (off_rd_q >= prev_off_q) ? (off_rd_q - prev_off_q) : '0;
            end
            step_d = step_q + SW'(1);
          end
          m_mask_d  = lit_d;
          m_ivl_d   = IVL_W'(ivl);
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      front_q   <= 1'b0;
      swap_q    <= 1'b0;
      bank_q    <= 1'b0;
      lit_q     <= '0;
      m_valid_q <= 1'b0;
      pass_q    <= '0;
      k_q       <= '0;
      moved_q   <= 1'b0;
      ord_vld_q <= '0;
      off_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      front_q   <= front_d;
      swap_q    <= swap_d;
      bank_q    <= bank_d;
      lit_q     <= lit_d;
      m_valid_q <= m_valid_d;
      pass_q    <= pass_d;
      k_q       <= k_d;
      moved_q   <= moved_d;
      if (ord_we) begin
        ord_vld_q[ord_wa] <= 1'b1;
      end
      if (off_we) begin
        off_vld_q[off_wa] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    carry_ord_q <= carry_ord_d;
    carry_off_q <= carry_off_d;
    new_ord_q   <= new_ord_d;
    prev_ord_q  <= prev_ord_d;
    prev_off_q  <= prev_off_d;
    cur_ord_q   <= cur_ord_d;
    m_mask_q    <= m_mask_d;
    m_ivl_q     <= m_ivl_d;
  end

  // order memory; never-written entries read as identity
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_rd_q <= ord_vld_q[ord_ra] ? ord_mem[ord_ra] : ord_ra[IW-1:0];
  end

  // off-time memory; never-written entries read as dark
  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[off_wa] <= off_wd;
    end
    off_rd_q <= off_vld_q[off_ra] ? off_mem[off_ra] : OW'(PWM_PERIOD);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_DATA_W'({m_ivl_q, m_mask_q});

  // checks
  `include "sorted_edge_pwm_scheduler_core_assert.svh"

  // compare event taken at the start of a pwm cycle
  logic chk_cyc_start;
  // cycle-end step forming its result
  logic chk_cyc_end;
  assign chk_cyc_start = s_fire && (s_axis_tuser == MODE_COMPARE) && (step_q == '0);
  assign chk_cyc_end   = (state_q == ST_C_RES) && (step_q == SW'(CHANNELS + 1)) &&
                         (!m_valid_q || m_axis_tready);

  `SEPWM_ASSERT_NOW(a_step_range, 1'b1, step_q <= SW'(CHANNELS + 1))
  `SEPWM_ASSERT_NOW(a_sort_index, (state_q == ST_S_CMP || state_q == ST_S_ORDN), k_q < pass_q)
  `SEPWM_ASSERT_NEXT(a_swap_taken, chk_cyc_start, !swap_q)
  `SEPWM_ASSERT_NEXT(a_cycle_end_dark, chk_cyc_end, (lit_q == '0 && m_mask_q == '0))

endmodule
